/* src/ste_pkg.sv */
package ste_pkg;

    // Defaults for the top level parameters.
    localparam int PIC_COLUMNS_DEF = 32;
    localparam int PIC_ROWS_DEF    = 32;
    localparam int TABLE_SIZE_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths.
    localparam int BIN_BITS   = 9;
    localparam int WIDTH_BITS = 24;
    localparam int GAIN_BITS  = 16;
    localparam int MASK_IN_BITS = 32;
    localparam int SINE_BITS  = 16;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_BIN_BASE  = 2'd1;
    localparam logic [1:0] REG_COL_WIDTH = 2'd2;
    localparam logic [1:0] REG_GAIN      = 2'd3;

    // Register reset values.
    localparam logic [BIN_BITS-1:0]   BIN_BASE_RST  = 9'd278;
    localparam logic [WIDTH_BITS-1:0] COL_WIDTH_RST = 24'd1024;
    localparam logic [GAIN_BITS-1:0]  GAIN_RST      = 16'd262;

    // Input modes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROWS,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT
    } t_state;

endpackage

/* src/ste_ram.sv */
module ste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/spectrogram_tone_embedder_core.sv */
// Spectrogram tone embedder.
// Input channel (i_in_valid / o_in_stall): an item with i_mode low loads the mask of
// column i_column_sel and causes no result; an item with i_mode high is one audio
// sample and causes exactly one result on the output channel (o_out_valid /
// i_out_stall). Results leave in the order their samples came in.
// After a mask load the next item may follow at once. A sample that passes
// unchanged (disabled, or the picture finished) goes from idle through the
// ST_OUT state into the output register. For an embedded sample the base
// phase is formed one bit of bin_base at a time in ST_MUL, then the sine table
// is read for each mask row in turn in ST_ROWS, followed by a drain of the
// three stage read, multiply and accumulate pipe in ST_DRAIN and a round and
// saturate step in ST_ROUND. One sample is worked on at a time.
// The output register holds a finished result while the receiver stalls; a
// next result waits in ST_OUT, stalling the input, until the register is free. Reset
// clears all masks (through valid bits), the picture position and the registers to
// their reset values. The sine table is a constant ROM. The user must write
// configuration through the APB port only while the block is idle; not enforced.
module spectrogram_tone_embedder_core #(
    parameter int PIC_COLUMNS = ste_pkg::PIC_COLUMNS_DEF,
    parameter int PIC_ROWS    = ste_pkg::PIC_ROWS_DEF,
    parameter int TABLE_SIZE  = ste_pkg::TABLE_SIZE_DEF,
    parameter int SAMPLE_BITS = ste_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic [4:0]                           i_column_sel,
    input  logic [ste_pkg::MASK_IN_BITS-1:0]     i_column_bits,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    // Output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out
);

    import ste_pkg::*;

    localparam int MASK_BITS = (PIC_ROWS < MASK_IN_BITS) ? PIC_ROWS : MASK_IN_BITS;
    localparam int RW    = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;
    localparam int AW    = (PIC_COLUMNS > 1) ? $clog2(PIC_COLUMNS) : 1;
    localparam int CW    = $clog2(PIC_COLUMNS + 1);
    localparam int PW    = $clog2(TABLE_SIZE);
    localparam int BBW   = $clog2(BIN_BITS);
    localparam int SHIFT = 32 - SAMPLE_BITS;
    localparam int TERM_W = GAIN_BITS + SINE_BITS + 1;
    localparam int ACC_W  = TERM_W + $clog2(MASK_BITS + 1) + 1;

    localparam logic [PW:0] TS = (PW + 1)'(TABLE_SIZE);
    localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(1) << SHIFT) >> 1;
    localparam logic signed [ACC_W-1:0] SMAX =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

    localparam longint unsigned HalfPiQ30 = 64'd1686629713;
    localparam longint unsigned OneQ30    = 64'd1073741824;

    // Quarter wave sine in Q1.15 from a truncated Taylor series in Q2.30.
    function automatic logic [SINE_BITS-1:0] f_quarter(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = r * HalfPiQ30 / TABLE_SIZE;
        x2 = (x * x) >> 30;
        t  = OneQ30 - x2 / 72;
        t  = OneQ30 - ((x2 * t) >> 30) / 42;
        t  = OneQ30 - ((x2 * t) >> 30) / 20;
        t  = OneQ30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_BITS-1:0];
    endfunction

    // Full wave table, entry p at bits [16p +: 16].
    function automatic logic [TABLE_SIZE*SINE_BITS-1:0] f_build();
        logic [TABLE_SIZE*SINE_BITS-1:0] tbl;
        longint unsigned n;
        longint unsigned u;
        logic [SINE_BITS-1:0] v;
        tbl = '0;
        n = longint'(TABLE_SIZE);
        for (int p = 0; p < TABLE_SIZE; p++) begin
            u = 4 * longint'(p);
            if (u <= n) begin
                v = f_quarter(u);
            end else if (u <= 2 * n) begin
                v = f_quarter(2 * n - u);
            end else if (u <= 3 * n) begin
                v = SINE_BITS'(0) - f_quarter(u - 2 * n);
            end else begin
                v = SINE_BITS'(0) - f_quarter(4 * n - u);
            end
            tbl[p*SINE_BITS +: SINE_BITS] = v;
        end
        return tbl;
    endfunction

    localparam logic [TABLE_SIZE*SINE_BITS-1:0] SINE_ROM = f_build();

    t_state r_state, n_state;

    // Configuration registers.
    logic                  r_enable;
    logic [BIN_BITS-1:0]   r_bin_base;
    logic [WIDTH_BITS-1:0] r_col_width;
    logic [GAIN_BITS-1:0]  r_gain;

    // Picture progress.
    logic [WIDTH_BITS-1:0] r_pos;
    logic [PW-1:0]         r_pos_mod;
    logic [CW-1:0]         r_col;
    logic [PIC_COLUMNS-1:0] r_mval;

    // Per sample work registers.
    logic [BBW-1:0]            r_bit;
    logic [RW-1:0]             r_row;
    logic [PW-1:0]             r_ph;
    logic [MASK_BITS-1:0]      r_mask;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SAMPLE_BITS-1:0] r_res;

    // Table read, multiply and accumulate pipe.
    logic                        r_s1_v;
    logic                        r_s1_lit;
    logic signed [SINE_BITS-1:0] r_sine;
    logic                        r_s2_v;
    logic signed [TERM_W-1:0]    r_term;

    // Output register.
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic                 w_cfg_we;
    logic                 w_accept;
    logic                 w_mask_we;
    logic                 w_embed;
    logic                 w_ld_out;
    logic [MASK_BITS-1:0] w_rdata;
    logic [PW:0]          w_dbl, w_dbl_m, w_add, w_add_m, w_row_s, w_row_m;
    logic [PW-1:0]        w_mul_next, w_row_next;
    logic signed [ACC_W-1:0] w_rsum, w_rshift;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic [WIDTH_BITS-1:0] w_width;
    logic [WIDTH_BITS:0]   w_pos_inc;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_ENABLE:    prdata = {31'd0, r_enable};
            REG_BIN_BASE:  prdata = 32'(r_bin_base);
            REG_COL_WIDTH: prdata = 32'(r_col_width);
            REG_GAIN:      prdata = 32'(r_gain);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_bin_base  <= BIN_BASE_RST;
            r_col_width <= COL_WIDTH_RST;
            r_gain      <= GAIN_RST;
        end else if (w_cfg_we) begin
            unique case (paddr[3:2])
                REG_ENABLE:    r_enable    <= pwdata[0];
                REG_BIN_BASE:  r_bin_base  <= pwdata[BIN_BITS-1:0];
                REG_COL_WIDTH: r_col_width <= pwdata[WIDTH_BITS-1:0];
                REG_GAIN:      r_gain      <= pwdata[GAIN_BITS-1:0];
                default:       r_enable    <= r_enable;
            endcase
        end
    end

    // Mask store, read at the current column.
    ste_ram #(
        .WIDTH (MASK_BITS),
        .DEPTH (PIC_COLUMNS)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (w_mask_we),
        .i_waddr (AW'(i_column_sel)),
        .i_wdata (i_column_bits[MASK_BITS-1:0]),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Handshake and control decode.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_accept   = i_in_valid && !o_in_stall;
        w_mask_we  = w_accept && (i_mode == MODE_LOAD) && (32'(i_column_sel) < PIC_COLUMNS);
        w_embed    = r_enable && (r_col < CW'(PIC_COLUMNS));
        w_ld_out   = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_mode == MODE_SAMPLE)) begin
                    n_state = w_embed ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                if (r_bit == '0) begin
                    n_state = ST_ROWS;
                end
            end
            ST_ROWS: begin
                if (r_row == RW'(MASK_BITS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: n_state = ST_OUT;
            ST_OUT: begin
                if (w_ld_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Base phase step: ph = 2*ph (+ pos) modulo the table size; row step: ph + pos.
    always_comb begin
        w_dbl   = {r_ph, 1'b0};
        w_dbl_m = (w_dbl >= TS) ? w_dbl - TS : w_dbl;
        w_add   = w_dbl_m + {1'b0, r_pos_mod};
        w_add_m = (w_add >= TS) ? w_add - TS : w_add;
        w_mul_next = r_bin_base[r_bit] ? w_add_m[PW-1:0] : w_dbl_m[PW-1:0];
        w_row_s = {1'b0, r_ph} + {1'b0, r_pos_mod};
        w_row_m = (w_row_s >= TS) ? w_row_s - TS : w_row_s;
        w_row_next = w_row_m[PW-1:0];
    end

    // Round half up and saturate; also the column width and the next position.
    always_comb begin
        w_rsum   = r_acc + HALF;
        w_rshift = w_rsum >>> SHIFT;
        if (w_rshift > SMAX) begin
            w_sat = SMAX[SAMPLE_BITS-1:0];
        end else if (w_rshift < SMIN) begin
            w_sat = SMIN[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_rshift[SAMPLE_BITS-1:0];
        end
        w_width   = (r_col_width == '0) ? WIDTH_BITS'(1) : r_col_width;
        w_pos_inc = {1'b0, r_pos} + (WIDTH_BITS + 1)'(1);
    end

    // Picture progress and mask valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pos_mod <= '0;
            r_col     <= '0;
            r_mval    <= '0;
        end else begin
            if (w_mask_we) begin
                r_mval[AW'(i_column_sel)] <= 1'b1;
            end
            if (r_state == ST_ROUND) begin
                if (w_pos_inc >= {1'b0, w_width}) begin
                    r_pos     <= '0;
                    r_pos_mod <= '0;
                    r_col     <= r_col + CW'(1);
                end else begin
                    r_pos     <= w_pos_inc[WIDTH_BITS-1:0];
                    r_pos_mod <= ({1'b0, r_pos_mod} + (PW + 1)'(1) == TS) ?
                                 '0 : r_pos_mod + PW'(1);
                end
            end
        end
    end

    // Sample work: phase, row walk, read, multiply and accumulate pipe and result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ph  <= '0;
                r_bit <= BBW'(BIN_BITS - 1);
                r_row <= '0;
                r_acc <= ACC_W'(i_sample_in) <<< SHIFT;
                r_res <= i_sample_in;
            end
            ST_MUL: begin
                if (r_bit == BBW'(BIN_BITS - 1)) begin
                    r_mask <= r_mval[r_col[AW-1:0]] ? w_rdata : '0;
                end
                r_ph  <= w_mul_next;
                r_bit <= r_bit - BBW'(1);
            end
            ST_ROWS: begin
                r_ph  <= w_row_next;
                r_row <= r_row + RW'(1);
            end
            ST_ROUND: begin
                r_res <= w_sat;
            end
            default: begin
                r_ph <= r_ph;
            end
        endcase
        if (r_s2_v) begin
            r_acc <= r_acc + ACC_W'(r_term);
        end
        r_s1_lit <= r_mask[r_row];
        r_sine   <= SINE_ROM[{r_ph, 4'b0000} +: SINE_BITS];
        // The product is signed; an unlit row adds nothing.
        if (r_s1_lit) begin
            r_term <= $signed({1'b0, r_gain}) * r_sine;
        end else begin
            r_term <= '0;
        end
    end

    // Pipe valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == ST_ROWS);
            r_s2_v <= r_s1_v;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule
